>>> hdl/positional_doubly_linked_list_macros.svh
// Assertion macros shared by the list RTL.
`ifndef POSITIONAL_DOUBLY_LINKED_LIST_MACROS_SVH
`define POSITIONAL_DOUBLY_LINKED_LIST_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PDLL_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pdll assertion failed");

// Next-cycle implication, checked out of reset.
`define PDLL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pdll assertion failed");

`endif

>>> hdl/pdll_pkg.sv
// Shared types and constants for the positional doubly linked list.
package pdll_pkg;

    localparam int CAPACITY   = 256;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int IDX_W      = ADDR_W + 1;
    localparam logic [IDX_W-1:0] NIL = IDX_W'(CAPACITY);

    // Request codes
    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_BEFORE = 2'd1;
    localparam logic [1:0] REQ_AFTER  = 2'd2;
    localparam logic [1:0] REQ_REMOVE = 2'd3;

    // Status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_NOPOS = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] value;
        logic [7:0]  position;
    } pdll_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] removed_value;
        logic [8:0]  element_count;
    } pdll_rsp_t;

endpackage

>>> hdl/pdll_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pdll_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/positional_doubly_linked_list.sv
// Top level: list sequencer over data, next-link and prev-link memories.
//
//  channel | direction | ports                      | beat
//  s_      | in        | s_valid s_ready s_data     | one request
//  m_      | out       | m_valid m_ready m_data     | one result
//
// A position past the end is answered without touching the memories; append
// allocates a node, reusing a freed node when there is one, and links it;
// remove and a positional insert first walk from the head to the position,
// each hop a next-link memory read and its registered data.
// A request is taken only when the sequencer is idle; the result register
// lets the next request start while a result waits for m_ready.
// Reset is synchronous on aresetn: the list is empty, memories need no clearing.
`include "positional_doubly_linked_list_macros.svh"

module positional_doubly_linked_list
    import pdll_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  pdll_req_t s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output pdll_rsp_t m_data
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_WALK   = 12'b000000000010,
        S_WWAIT  = 12'b000000000100,
        S_TRD    = 12'b000000001000,
        S_TWAIT  = 12'b000000010000,
        S_REM1   = 12'b000000100000,
        S_REM2   = 12'b000001000000,
        S_ALLOC  = 12'b000010000000,
        S_AWAIT  = 12'b000100000000,
        S_LINK1  = 12'b001000000000,
        S_LINK2  = 12'b010000000000,
        S_RESULT = 12'b100000000000
    } state_t;

    state_t           state_reg, state_next;
    pdll_req_t        req_reg, req_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [IDX_W-1:0] free_reg, free_next;
    logic [IDX_W-1:0] unused_reg, unused_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [7:0]       idx_reg, idx_next;
    logic [IDX_W-1:0] tprev_reg, tprev_next;
    logic [IDX_W-1:0] tnext_reg, tnext_next;
    logic [31:0]      tdata_reg, tdata_next;
    logic [IDX_W-1:0] node_reg, node_next;
    logic [1:0]       status_reg, status_next;
    logic [31:0]      removed_reg, removed_next;
    logic             m_valid_reg, m_valid_next;
    pdll_rsp_t        m_data_reg, m_data_next;

    // Memory ports
    logic [ADDR_W-1:0] rd_addr;
    logic              data_we, next_we, prev_we;
    logic [ADDR_W-1:0] data_waddr, next_waddr, prev_waddr;
    logic [31:0]       data_wdata, data_rdata;
    logic [IDX_W-1:0]  next_wdata, next_rdata, prev_wdata, prev_rdata;

    // Neighbors of the new node
    logic [IDX_W-1:0] link_a, link_b;

    pdll_ram #(.DEPTH(CAPACITY), .WIDTH(DATA_WIDTH)) u_data_ram (
        .aclk(aclk), .we(data_we), .waddr(data_waddr), .wdata(data_wdata),
        .raddr(rd_addr), .rdata(data_rdata)
    );

    pdll_ram #(.DEPTH(CAPACITY), .WIDTH(IDX_W)) u_next_ram (
        .aclk(aclk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
        .raddr(rd_addr), .rdata(next_rdata)
    );

    pdll_ram #(.DEPTH(CAPACITY), .WIDTH(IDX_W)) u_prev_ram (
        .aclk(aclk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
        .raddr(rd_addr), .rdata(prev_rdata)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Read address: free-list head while allocating, else the walk cursor
    assign rd_addr = (state_reg == S_ALLOC) ? free_reg[ADDR_W-1:0] : cur_reg[ADDR_W-1:0];

    // Neighbors for the insert kinds
    always_comb begin
        case (req_reg.req_type)
            REQ_APPEND: begin
                link_a = tail_reg;
                link_b = NIL;
            end
            REQ_BEFORE: begin
                link_a = tprev_reg;
                link_b = cur_reg;
            end
            default: begin
                link_a = cur_reg;
                link_b = tnext_reg;
            end
        endcase
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        free_next    = free_reg;
        unused_next  = unused_reg;
        count_next   = count_reg;
        cur_next     = cur_reg;
        idx_next     = idx_reg;
        tprev_next   = tprev_reg;
        tnext_next   = tnext_reg;
        tdata_next   = tdata_reg;
        node_next    = node_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        data_we      = 1'b0;
        next_we      = 1'b0;
        prev_we      = 1'b0;
        data_waddr   = node_reg[ADDR_W-1:0];
        data_wdata   = req_reg.value;
        next_waddr   = node_reg[ADDR_W-1:0];
        next_wdata   = link_b;
        prev_waddr   = node_reg[ADDR_W-1:0];
        prev_wdata   = link_a;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next     = s_data;
                    removed_next = '0;
                    status_next  = ST_DONE;
                    cur_next     = head_reg;
                    idx_next     = '0;
                    if (s_data.req_type == REQ_APPEND) begin
                        state_next = S_ALLOC;
                    end else if ({1'b0, s_data.position} >= count_reg) begin
                        status_next = ST_NOPOS;
                        state_next  = S_RESULT;
                    end else if (s_data.position == 8'd0) begin
                        state_next = S_TRD;
                    end else begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK: begin
                state_next = S_WWAIT;
            end
            S_WWAIT: begin
                cur_next = next_rdata;
                idx_next = idx_reg + 8'd1;
                state_next = ((idx_reg + 8'd1) == req_reg.position) ? S_TRD : S_WALK;
            end
            S_TRD: begin
                state_next = S_TWAIT;
            end
            S_TWAIT: begin
                tprev_next = prev_rdata;
                tnext_next = next_rdata;
                tdata_next = data_rdata;
                state_next = (req_reg.req_type == REQ_REMOVE) ? S_REM1 : S_ALLOC;
            end
            S_REM1: begin
                // unlink target from its neighbors
                if (tprev_reg != NIL) begin
                    next_we    = 1'b1;
                    next_waddr = tprev_reg[ADDR_W-1:0];
                    next_wdata = tnext_reg;
                end else begin
                    head_next = tnext_reg;
                end
                if (tnext_reg != NIL) begin
                    prev_we    = 1'b1;
                    prev_waddr = tnext_reg[ADDR_W-1:0];
                    prev_wdata = tprev_reg;
                end else begin
                    tail_next = tprev_reg;
                end
                count_next   = count_reg - IDX_W'(1);
                removed_next = tdata_reg;
                state_next   = S_REM2;
            end
            S_REM2: begin
                // push target on the free list
                next_we    = 1'b1;
                next_waddr = cur_reg[ADDR_W-1:0];
                next_wdata = free_reg;
                free_next  = cur_reg;
                state_next = S_RESULT;
            end
            S_ALLOC: begin
                if (free_reg != NIL) begin
                    state_next = S_AWAIT;
                end else if (unused_reg != NIL) begin
                    node_next   = unused_reg;
                    unused_next = unused_reg + IDX_W'(1);
                    state_next  = S_LINK1;
                end else begin
                    status_next = ST_FULL;
                    state_next  = S_RESULT;
                end
            end
            S_AWAIT: begin
                node_next  = free_reg;
                free_next  = next_rdata;
                state_next = S_LINK1;
            end
            S_LINK1: begin
                // fill the new node
                data_we    = 1'b1;
                next_we    = 1'b1;
                prev_we    = 1'b1;
                state_next = S_LINK2;
            end
            S_LINK2: begin
                // point the neighbors at the new node
                if (link_a != NIL) begin
                    next_we    = 1'b1;
                    next_waddr = link_a[ADDR_W-1:0];
                    next_wdata = node_reg;
                end else begin
                    head_next = node_reg;
                end
                if (link_b != NIL) begin
                    prev_we    = 1'b1;
                    prev_waddr = link_b[ADDR_W-1:0];
                    prev_wdata = node_reg;
                end else begin
                    tail_next = node_reg;
                end
                count_next = count_reg + IDX_W'(1);
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.status        = status_reg;
                    m_data_next.removed_value = removed_reg;
                    m_data_next.element_count = 9'(count_reg);
                    state_next                = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= NIL;
            tail_reg    <= NIL;
            free_reg    <= NIL;
            unused_reg  <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            free_reg    <= free_next;
            unused_reg  <= unused_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        cur_reg     <= cur_next;
        idx_reg     <= idx_next;
        tprev_reg   <= tprev_next;
        tnext_reg   <= tnext_next;
        tdata_reg   <= tdata_next;
        node_reg    <= node_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
        m_data_reg  <= m_data_next;
    end

    `PDLL_ASSERT_IMPL(a_count_range, aclk, aresetn, 1'b1, count_reg <= NIL)
    `PDLL_ASSERT_IMPL(a_head_empty, aclk, aresetn, 1'b1, (head_reg == NIL) == (count_reg == '0))
    `PDLL_ASSERT_IMPL(a_tail_empty, aclk, aresetn, 1'b1, (tail_reg == NIL) == (count_reg == '0))
    `PDLL_ASSERT_NEXT(a_busy_after_take, aclk, aresetn, s_valid && s_ready, state_reg != S_IDLE)

endmodule
